/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define OKST_ASSERT_IMPLY(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define OKST_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

/* rtl/okst_pkg.sv */
// Package: sizes, request and status codes, state type and cell control struct.
`default_nettype none
package okst_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int KEY_W    = 64;

    // request kinds
    localparam logic [1:0] REQ_FIND = 2'd0;
    localparam logic [1:0] REQ_PUSH = 2'd1;
    localparam logic [1:0] REQ_PULL = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_HIT      = 2'd0;
    localparam logic [1:0] STAT_MISS     = 2'd1;
    localparam logic [1:0] STAT_INSERTED = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_ACT
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              cmp_en;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  count;
        logic              shift_en;
        logic [IDX_W-1:0]  shift_pos;
        logic              push_en;
    } cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/okst_cell.sv */
// Cell: holds and compares a key; takes the upper key on a pull, the new key on a push.
`default_nettype none
module okst_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire okst_pkg::cell_ctl_t       ctl,
    input  wire logic [okst_pkg::IDX_W-1:0] cell_idx,
    input  wire logic [okst_pkg::KEY_W-1:0] up_key,
    output logic      [okst_pkg::KEY_W-1:0] key_out,
    output logic                           hit_out
);
    import okst_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic             hit_reg;
    logic             occupied;

    // cell holds a live key when its index is below the fill count
    assign occupied = ({1'b0, cell_idx} < ctl.count);

    // match flag, registered for the action cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (ctl.cmp_en) begin
            hit_reg <= occupied && (key_reg == ctl.key);
        end
    end

    // compaction shift from the neighbor above, or append at the fill point
    always_ff @(posedge aclk) begin
        if (ctl.shift_en && (cell_idx >= ctl.shift_pos)) begin
            key_reg <= up_key;
        end else if (ctl.push_en && ({1'b0, cell_idx} == ctl.count)) begin
            key_reg <= ctl.key;
        end
    end

    assign key_out = key_reg;
    assign hit_out = hit_reg;

endmodule
`default_nettype wire

/* rtl/ordered_key_set_table.sv */
// Top level: ordered key set held in a chain of compare-and-shift cells.
//
// Usage:
//   s_ channel carries one request per item: kind (find, push, pull),
//   a 64-bit key and a start hint. The hint is not needed, since every
//   cell compares in parallel.
//   m_ channel returns one result per request: status, position and the
//   number of keys held afterwards.
//   After an item is accepted, all cells compare its key in parallel in
//   the compare step; the action step then encodes the match, applies
//   the insert or the compaction shift by one position, and loads the
//   output register. The controller handles one item at a time through
//   its idle, compare and action steps, accepting a new item only in idle.
//   Reset (aresetn low, synchronous) empties the table; stored keys are
//   not cleared, the fill count alone marks which cells are live.
//   A stalled receiver: the result stays in the output register; one more
//   item is accepted and compared, then waits in its action step until
//   the output register frees.
`default_nettype none
module ordered_key_set_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // [1:0] req_type, [65:2] key, [71:66] hint_index
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata   // [1:0] status, [7:2] position, [14:8] entry_total
);
    import okst_pkg::*;

    state_t            state_reg, state_next;
    logic [1:0]        req_type_reg;
    logic [KEY_W-1:0]  req_key_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;

    logic [KEY_W-1:0]  cell_keys [CAPACITY];
    logic [CAPACITY-1:0] hit_vec;
    cell_ctl_t         ctl;

    logic              hit_any;
    logic [IDX_W-1:0]  hit_pos;
    logic              full;
    logic              out_free;
    logic              fire;
    logic [1:0]        res_status;
    logic [IDX_W-1:0]  res_pos;

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] up_key;
        if (g == CAPACITY - 1) begin : g_top
            assign up_key = '0;
        end else begin : g_mid
            assign up_key = cell_keys[g + 1];
        end
        okst_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .cell_idx (IDX_W'(g)),
            .up_key   (up_key),
            .key_out  (cell_keys[g]),
            .hit_out  (hit_vec[g])
        );
    end

    // match encode: keys are unique, so at most one hit
    always_comb begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (hit_vec[i]) begin
                hit_pos = hit_pos | IDX_W'(i);
            end
        end
    end

    assign hit_any  = |hit_vec;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = (state_reg == S_ACT) && out_free;

    // request decode into result and table update
    always_comb begin
        res_status = STAT_MISS;
        res_pos    = '0;
        count_next = count_reg;
        case (req_type_reg)
            REQ_FIND: begin
                if (hit_any) begin
                    res_status = STAT_HIT;
                    res_pos    = hit_pos;
                end
            end
            REQ_PUSH: begin
                if (hit_any) begin
                    res_status = STAT_HIT;
                    res_pos    = hit_pos;
                end else if (full) begin
                    res_status = STAT_FULL;
                end else begin
                    res_status = STAT_INSERTED;
                    res_pos    = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_PULL: begin
                if (hit_any) begin
                    res_status = STAT_HIT;
                    res_pos    = hit_pos;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
                res_status = STAT_MISS;
            end
        endcase
    end

    // broadcast control to the cells
    always_comb begin
        ctl.cmp_en    = (state_reg == S_CMP);
        ctl.key       = req_key_reg;
        ctl.count     = count_reg;
        ctl.shift_en  = fire && (req_type_reg == REQ_PULL) && hit_any;
        ctl.shift_pos = hit_pos;
        ctl.push_en   = fire && (req_type_reg == REQ_PUSH) && !hit_any && !full;
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and handshake
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_ACT;
            end
            S_ACT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_type_reg <= s_tdata[1:0];
            req_key_reg  <= s_tdata[65:2];
        end
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (fire) begin
            count_reg <= count_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= {1'b0, count_next, res_pos, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

/* rtl/okst_checker.sv */
// Port-level checker for the key set table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module okst_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);
    import okst_pkg::*;

    // a stalled result holds
    `OKST_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))
    // one item at a time: no accept right after an accept
    `OKST_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // count never exceeds capacity
    `OKST_ASSERT_IMPLY(a_total_range, aclk, aresetn, m_tvalid,
        m_tdata[14:8] <= CNT_W'(CAPACITY))
    // misses and rejects carry position zero
    `OKST_ASSERT_IMPLY(a_miss_pos, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[7:2] == 6'd0)
    // a rejected push only happens on a full table
    `OKST_ASSERT_IMPLY(a_full_total, aclk, aresetn, m_tvalid && (m_tdata[1:0] == STAT_FULL),
        m_tdata[14:8] == CNT_W'(CAPACITY))

endmodule

bind ordered_key_set_table okst_checker u_okst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

/* sim/ordered_key_set_table_tb.sv */
// Testbench for the ordered key set table: random and directed requests checked against a model.
`timescale 1ns / 100ps

// one answer as it travels on m_tdata, status in the lowest bits
typedef struct packed {
    logic [6:0] entry_total;
    logic [5:0] position;
    logic [1:0] status;
} set_answer_t;

// Tracks the keys the table should hold and the answers still owed by the block.
class key_set_scoreboard;
    logic [63:0]  held_keys [okst_pkg::CAPACITY];
    int unsigned  held_count;
    set_answer_t  pending_answers [$];
    int           errors;

    function new();
        held_count = 0;
        errors     = 0;
    endfunction

    // index of a held key, -1 when absent
    function int locate_key(logic [63:0] k);
        for (int i = 0; i < held_count; i++) begin
            if (held_keys[i] == k) return i;
        end
        return -1;
    endfunction

    // apply one request to the shadow table and queue the answer it should give
    function void note_request(logic [1:0] req, logic [63:0] k);
        set_answer_t ans;
        int          at;
        at              = locate_key(k);
        ans.status      = okst_pkg::STAT_MISS;
        ans.position    = '0;
        case (req)
            okst_pkg::REQ_FIND: begin
                if (at >= 0) begin
                    ans.status   = okst_pkg::STAT_HIT;
                    ans.position = at[5:0];
                end
            end
            okst_pkg::REQ_PUSH: begin
                if (at >= 0) begin
                    ans.status   = okst_pkg::STAT_HIT;
                    ans.position = at[5:0];
                end else if (held_count >= okst_pkg::CAPACITY) begin
                    ans.status   = okst_pkg::STAT_FULL;
                end else begin
                    held_keys[held_count] = k;
                    ans.position          = held_count[5:0];
                    ans.status            = okst_pkg::STAT_INSERTED;
                    held_count++;
                end
            end
            okst_pkg::REQ_PULL: begin
                if (at >= 0) begin
                    ans.status   = okst_pkg::STAT_HIT;
                    ans.position = at[5:0];
                    held_count--;
                    // close the gap, later keys keep their order
                    for (int i = at; i < held_count; i++) held_keys[i] = held_keys[i + 1];
                end
            end
            default: ;
        endcase
        ans.entry_total = held_count[6:0];
        pending_answers.push_back(ans);
    endfunction

    // compare one accepted result with the oldest answer owed
    function void check_result(logic [15:0] word);
        set_answer_t want;
        set_answer_t got;
        got = word[14:0];
        if (pending_answers.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, word);
            errors++;
            return;
        end
        want = pending_answers.pop_front();
        if (got.status != want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
        end
        if (got.position != want.position) begin
            $display("%0t: position mismatch, expected %0d, actual %0d",
                     $time, want.position, got.position);
            errors++;
        end
        if (got.entry_total != want.entry_total) begin
            $display("%0t: entry_total mismatch, expected %0d, actual %0d",
                     $time, want.entry_total, got.entry_total);
            errors++;
        end
    endfunction
endclass

module ordered_key_set_table_tb;
    import okst_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         POOL_SIZE   = 96;
    localparam int         RANDOM_REQS = 850;
    localparam int         IDLE_LIMIT  = 2000;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED,
        PH_NOISE
    } phase_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // [1:0] req_type, [65:2] key, [71:66] hint_index
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [1:0] status, [7:2] position, [14:8] entry_total

    key_set_scoreboard board;
    logic [63:0]       key_pool [POOL_SIZE];
    bit                burst;
    int                hold_left;
    int                idle_cycles;
    int                fill_cursor;

    ordered_key_set_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // result side: check at the edge, then draw a stall for the next item
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata);
            hold_left = burst ? 0 : $urandom_range(0, 15);
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any item moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // drive one request; entered and left at a falling edge
    task automatic send_request(input logic [1:0] req, input logic [63:0] k,
                                input logic [5:0] hint);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hint, k, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(req, k);
        @(negedge aclk);
    endtask

    // hold off the sender until every answer owed has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending_answers.size() > 0) @(negedge aclk);
    endtask

    // one random request shaped by the current phase
    task automatic send_random(input phase_t ph);
        logic [1:0]  req;
        logic [63:0] k;
        int          roll;
        roll = $urandom_range(0, 99);
        k    = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        case (ph)
            PH_FILL: begin
                if (roll < 85) begin
                    req         = REQ_PUSH;
                    k           = key_pool[fill_cursor % POOL_SIZE];
                    fill_cursor++;
                end else begin
                    req = roll < 93 ? REQ_FIND : REQ_PULL;
                end
            end
            PH_DRAIN: begin
                req = roll < 80 ? REQ_PULL : (roll < 90 ? REQ_FIND : REQ_PUSH);
            end
            PH_MIXED: begin
                req = 2'($urandom_range(0, 2));
                if (roll < 25) k = {$urandom, $urandom};
            end
            default: begin
                // noise: any code, mostly fresh keys
                req = 2'($urandom_range(0, 3));
                if (roll < 70) k = {$urandom, $urandom};
            end
        endcase
        send_request(req, k, 6'($urandom_range(0, 63)));
    endtask

    initial begin
        phase_t ph;
        int     sent;
        int     phase_no;
        int     len;

        board       = new();
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        burst       = 1'b0;
        hold_left   = 0;
        idle_cycles = 0;
        fill_cursor = 0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extreme keys, duplicates, compaction, unused code
        send_request(REQ_FIND,   64'h0,                 6'd0);
        send_request(REQ_PULL,   64'h0,                 6'd63);
        send_request(REQ_UNUSED, 64'h0,                 6'd0);
        send_request(REQ_PUSH,   64'h0,                 6'd0);
        send_request(REQ_PUSH,   64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        send_request(REQ_PUSH,   64'h0,                 6'd63);
        send_request(REQ_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
        send_request(REQ_FIND,   64'h5555_5555_5555_5555, 6'd21);
        send_request(REQ_PUSH,   64'hAAAA_AAAA_AAAA_AAAA, 6'd42);
        send_request(REQ_PUSH,   64'h5555_5555_5555_5555, 6'd1);
        send_request(REQ_PULL,   64'h0,                 6'd5);
        send_request(REQ_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        send_request(REQ_FIND,   64'h5555_5555_5555_5555, 6'd0);
        send_request(REQ_PULL,   64'h5555_5555_5555_5555, 6'd2);
        send_request(REQ_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        send_request(REQ_PULL,   64'h1234_5678_9ABC_DEF0, 6'd10);
        send_request(REQ_PUSH,   64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
        send_request(REQ_PULL,   64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
        send_request(REQ_PULL,   64'hAAAA_AAAA_AAAA_AAAA, 6'd63);
        send_request(REQ_FIND,   64'hAAAA_AAAA_AAAA_AAAA, 6'd33);
        wait_drained();

        // random phases; the first fills the table past capacity
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_REQS) begin
            ph    = phase_no == 0 ? PH_FILL : phase_t'($urandom_range(0, 3));
            burst = $urandom_range(0, 3) == 0;
            len   = ph == PH_FILL ? 110 : $urandom_range(40, 120);
            if (len > RANDOM_REQS - sent) len = RANDOM_REQS - sent;
            for (int i = 0; i < len; i++) send_random(ph);
            sent += len;
            wait_drained();
            phase_no++;
        end

        // let the pipeline settle
        burst = 1'b0;
        repeat (10) @(negedge aclk);
        if (board.errors == 0 && board.pending_answers.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/okst_pkg.sv
rtl/okst_cell.sv
rtl/ordered_key_set_table.sv
rtl/okst_checker.sv
sim/ordered_key_set_table_tb.sv
